>>> rtl/ces_pkg.sv
// Shared widths, constants and the month-offset table for the epoch seconds converter.
package ces_pkg;

   localparam int unsigned YearWidth   = 7;
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned DomWidth    = 5;
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned SecondWidth = 6;
   localparam int unsigned EpochWidth  = 32;

   localparam int unsigned ReqFieldBits = YearWidth + MonthWidth + DomWidth
                                        + HourWidth + MinuteWidth + SecondWidth;
   localparam int unsigned ReqDataWidth = ((ReqFieldBits + 7) / 8) * 8;
   localparam int unsigned RspDataWidth = ((EpochWidth + 7) / 8) * 8;

   // day count: signed, -1 for Jan 1 of year 0 with day zero, max below 2^16
   localparam int unsigned DayWidth     = 17;
   localparam int unsigned YearDayWidth = 16;
   localparam int unsigned MonDayWidth  = 9;
   localparam int unsigned HourSecWidth = 17;   // 31 * 3600
   localparam int unsigned MinSecWidth  = 12;   // 63 * 60 + 63
   localparam int unsigned TodWidth     = 18;

   localparam int unsigned DaysPerYear    = 365;
   localparam int unsigned SecondsPerDay  = 86400;
   localparam int unsigned SecondsPerHour = 3600;
   localparam int unsigned SecondsPerMin  = 60;
   localparam int unsigned CenturyYear    = 100;   // 2100, not a leap year

   // Days before the first of each month in a common year. Codes 12..15
   // repeat the offsets of codes 7..10.
   function automatic logic [MonDayWidth-1:0] month_offset(input logic [MonthWidth-1:0] mon);
      logic [MonDayWidth-1:0] off;
      unique case (mon)
         4'd0:  off = 9'd0;
         4'd1:  off = 9'd31;
         4'd2:  off = 9'd59;
         4'd3:  off = 9'd90;
         4'd4:  off = 9'd120;
         4'd5:  off = 9'd151;
         4'd6:  off = 9'd181;
         4'd7:  off = 9'd212;
         4'd8:  off = 9'd243;
         4'd9:  off = 9'd273;
         4'd10: off = 9'd304;
         4'd11: off = 9'd334;
         4'd12: off = 9'd212;
         4'd13: off = 9'd243;
         4'd14: off = 9'd273;
         4'd15: off = 9'd304;
         default: off = '0;
      endcase
      return off;
   endfunction

endpackage

>>> rtl/ces_day_count.sv
// Day count since 2000-01-01 from year, month and day of month.
module ces_day_count (
   input  logic [ces_pkg::YearWidth-1:0]   year_offset,
   input  logic [ces_pkg::MonthWidth-1:0]  month_index,
   input  logic [ces_pkg::DomWidth-1:0]    day_of_month,
   output logic [ces_pkg::DayWidth-1:0]    day_count
);

   logic [ces_pkg::YearWidth-1:0]    prev_year;
   logic [ces_pkg::YearDayWidth-1:0] year_days;
   logic [ces_pkg::YearDayWidth-1:0] leap_days;
   logic                             leap_year;
   logic                             leap_add;
   logic [ces_pkg::MonDayWidth-1:0]  mon_days;

   assign prev_year = year_offset - ces_pkg::YearWidth'(1);

   // leap days in earlier years; year 0 has none before it
   always_comb begin
      if (year_offset == '0) begin
         leap_days = '0;
      end else begin
         leap_days = ces_pkg::YearDayWidth'(prev_year[ces_pkg::YearWidth-1:2])
                   - ces_pkg::YearDayWidth'(prev_year >= ces_pkg::YearWidth'(ces_pkg::CenturyYear))
                   + ces_pkg::YearDayWidth'(1);
      end
   end

   assign year_days = ces_pkg::YearDayWidth'(year_offset * ces_pkg::YearDayWidth'(ces_pkg::DaysPerYear))
                    + leap_days;

   // 2000 is leap, 2100 is not
   assign leap_year = (year_offset[1:0] == 2'b00)
                   && (year_offset != ces_pkg::YearWidth'(ces_pkg::CenturyYear));
   assign leap_add  = leap_year && (month_index >= ces_pkg::MonthWidth'(2));
   assign mon_days  = ces_pkg::month_offset(month_index);

   assign day_count = ces_pkg::DayWidth'(year_days)
                    + ces_pkg::DayWidth'(mon_days)
                    + ces_pkg::DayWidth'(leap_add)
                    + ces_pkg::DayWidth'(day_of_month)
                    - ces_pkg::DayWidth'(1);

endmodule

>>> rtl/calendar_to_epoch_seconds_unit.sv
// Top level: broken-down time to seconds since 2000-01-01, three-stage pipeline.
//
//   port group | dir | word contents
//   req_*      | in  | year, month, day, hour, minute, second (one time stamp)
//   rsp_*      | out | epoch_seconds (32-bit seconds since 2000-01-01 00:00:00)
//
// One word in per cycle, one word out per cycle, while rsp_tready is high.
// Stage 1 forms the day count and hour/minute seconds, stage 2 the
// days * 86400 product and time of day, stage 3 (output register) the sum.
// Each stage holds its word while the stage after it is full and stalled;
// ready ripples back so no word is lost or repeated.
// Synchronous reset clears all stage valid bits.
module calendar_to_epoch_seconds_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] year_offset, [10:7] month_index, [15:11] day_of_month,
   // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute, [39:33] zero
   input  logic [ces_pkg::ReqDataWidth-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] epoch_seconds
   output logic [ces_pkg::RspDataWidth-1:0] rsp_tdata
);

   localparam int unsigned MonLo  = ces_pkg::YearWidth;
   localparam int unsigned DomLo  = MonLo + ces_pkg::MonthWidth;
   localparam int unsigned HourLo = DomLo + ces_pkg::DomWidth;
   localparam int unsigned MinLo  = HourLo + ces_pkg::HourWidth;
   localparam int unsigned SecLo  = MinLo + ces_pkg::MinuteWidth;

   logic [ces_pkg::YearWidth-1:0]   year_offset;
   logic [ces_pkg::MonthWidth-1:0]  month_index;
   logic [ces_pkg::DomWidth-1:0]    day_of_month;
   logic [ces_pkg::HourWidth-1:0]   hour_of_day;
   logic [ces_pkg::MinuteWidth-1:0] minute_of_hour;
   logic [ces_pkg::SecondWidth-1:0] second_of_minute;

   assign year_offset      = req_tdata[MonLo-1:0];
   assign month_index      = req_tdata[DomLo-1:MonLo];
   assign day_of_month     = req_tdata[HourLo-1:DomLo];
   assign hour_of_day      = req_tdata[MinLo-1:HourLo];
   assign minute_of_hour   = req_tdata[SecLo-1:MinLo];
   assign second_of_minute = req_tdata[SecLo+ces_pkg::SecondWidth-1:SecLo];

   // stage handshake: a stage moves when it is empty or the next one moves
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_adv, s2_adv, s3_adv;

   assign s3_adv     = !s3_valid_ff || rsp_tready;
   assign s2_adv     = !s2_valid_ff || s3_adv;
   assign s1_adv     = !s1_valid_ff || s2_adv;
   assign req_tready = s1_adv;

   assign s1_valid_in = s1_adv ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // stage 1: day count, hour seconds, minute+second seconds
   logic [ces_pkg::DayWidth-1:0]     day_cnt_ff, day_cnt_in;
   logic [ces_pkg::HourSecWidth-1:0] hour_sec_ff, hour_sec_in;
   logic [ces_pkg::MinSecWidth-1:0]  min_sec_ff, min_sec_in;

   ces_day_count u_day_count (
      .year_offset  (year_offset),
      .month_index  (month_index),
      .day_of_month (day_of_month),
      .day_count    (day_cnt_in)
   );

   assign hour_sec_in = ces_pkg::HourSecWidth'(hour_of_day
                      * ces_pkg::HourSecWidth'(ces_pkg::SecondsPerHour));
   assign min_sec_in  = ces_pkg::MinSecWidth'(minute_of_hour
                      * ces_pkg::MinSecWidth'(ces_pkg::SecondsPerMin))
                      + ces_pkg::MinSecWidth'(second_of_minute);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         day_cnt_ff  <= day_cnt_in;
         hour_sec_ff <= hour_sec_in;
         min_sec_ff  <= min_sec_in;
      end
   end

   // stage 2: day count (sign-extended, wraps mod 2^32) times 86400, time of day
   logic [ces_pkg::EpochWidth-1:0] day_cnt_ext;
   logic [ces_pkg::EpochWidth-1:0] day_sec_ff, day_sec_in;
   logic [ces_pkg::TodWidth-1:0]   tod_ff, tod_in;

   assign day_cnt_ext = {{(ces_pkg::EpochWidth-ces_pkg::DayWidth){day_cnt_ff[ces_pkg::DayWidth-1]}},
                         day_cnt_ff};
   assign day_sec_in  = ces_pkg::EpochWidth'(day_cnt_ext
                      * ces_pkg::EpochWidth'(ces_pkg::SecondsPerDay));
   assign tod_in      = ces_pkg::TodWidth'(hour_sec_ff) + ces_pkg::TodWidth'(min_sec_ff);

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         day_sec_ff <= day_sec_in;
         tod_ff     <= tod_in;
      end
   end

   // stage 3: output register
   logic [ces_pkg::EpochWidth-1:0] epoch_ff, epoch_in;

   assign epoch_in = day_sec_ff + ces_pkg::EpochWidth'(tod_ff);

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         epoch_ff <= epoch_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = ces_pkg::RspDataWidth'(epoch_ff);

   // checks
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted word did not enter stage 1");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && !rsp_tready))
      else $error("input stalled while pipeline has room");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_adv |=> s1_valid_ff && $stable(day_cnt_ff) && $stable(min_sec_ff))
      else $error("stage 1 word changed under stall");

   a_s2_moves: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s3_adv |=> s3_valid_ff)
      else $error("stage 2 word dropped");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
